/* design/mrts_pkg.sv */
// Package: shared types, constants and function codes for the range table.
package mrts_pkg;

	localparam int MaxEntries = 32;
	localparam int IdxW       = $clog2(MaxEntries);
	localparam int CntW       = 6;

	typedef enum logic [1:0] {
		FUNC_ADD    = 2'd0,
		FUNC_SEAL   = 2'd1,
		FUNC_GET    = 2'd2,
		FUNC_RETYPE = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_REJECT = 2'd1,
		ST_FULL   = 2'd2,
		ST_SEALED = 2'd3
	} status_t;

	localparam logic CFG_RAM  = 1'b0;
	localparam logic CFG_SOFT = 1'b1;

	typedef struct packed {
		logic [1:0]  func;
		logic [63:0] range_base;
		logic [63:0] range_length;
		logic [31:0] range_type;
		logic [7:0]  entry_index;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] found_base;
		logic [63:0] found_length;
		logic [5:0]  entry_count;
	} out_item_t;

	typedef struct packed {
		logic [63:0] base;
		logic [63:0] length;
		logic [31:0] rtype;
	} entry_t;

	// Controls from the sequencer to every cell of the chain.
	typedef enum logic [1:0] {
		CELL_HOLD  = 2'd0,
		CELL_ROT   = 2'd1,
		CELL_LOAD  = 2'd2
	} cell_op_t;

	typedef enum logic [2:0] {
		S_IDLE   = 3'd0,
		S_SCAN   = 3'd1,
		S_DECIDE = 3'd2,
		S_ROT    = 3'd3,
		S_APPEND = 3'd4,
		S_DONE   = 3'd5
	} state_t;

endpackage

/* design/mrts_cell.sv */
// One cell of the entry chain: holds an entry and passes it to its neighbour.
module mrts_cell (
	input  logic              clk,
	input  mrts_pkg::cell_op_t op,
	input  mrts_pkg::entry_t  prev,
	input  mrts_pkg::entry_t  load,
	input  logic              load_en,
	output mrts_pkg::entry_t  ent
);

	mrts_pkg::entry_t ent_q;

	// Rotate towards the head; while loading, the tail takes a new entry instead.
	always_ff @(posedge clk) begin
		case (op)
			mrts_pkg::CELL_ROT: ent_q <= prev;
			mrts_pkg::CELL_LOAD: ent_q <= load_en ? load : prev;
			default: ent_q <= ent_q;
		endcase
	end

	assign ent = ent_q;

endmodule

/* design/memory_range_table_split.sv */
// Top level: range table built as a rotating chain of entry cells.
// Add, seal, get and refused retype: one full rotation of the chain in the scan state, then the
// decide state and the result state, in which done is strobed.
// A retype that goes ahead rotates twice (scan, then drop and append) before the result state;
// the block takes no new item until it is back in idle, and results are never held.
// Reset clears count, sealed flag and state, sets the type codes; entry cells hold no reset value.
module memory_range_table_split (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  mrts_pkg::in_item_t  in_item,
	output logic                busy,
	output logic                done,
	output mrts_pkg::out_item_t out_item,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [31:0]         cfg_data
);

	localparam int N  = mrts_pkg::MaxEntries;
	localparam int IW = mrts_pkg::IdxW;
	localparam int CW = mrts_pkg::CntW;

	mrts_pkg::entry_t       ent [N];
	mrts_pkg::cell_op_t     cop;
	mrts_pkg::entry_t       load_ent;
	logic                   tail_load;
	mrts_pkg::state_t       state_q, state_d;
	mrts_pkg::in_item_t     req_q;
	logic [63:0]            end_q;
	logic [31:0]            ram_q, soft_q;
	logic [CW-1:0]          count_q;
	logic                   sealed_q;
	logic [CW-1:0]          step_q;
	logic                   hit_q, inram_q;
	logic [IW-1:0]          hitidx_q;
	mrts_pkg::entry_t       hitent_q;
	logic [63:0]            hend_q;
	logic                   lower_q, upper_q;
	logic [1:0]             pieces_q;
	logic [1:0]             status_q;
	logic [63:0]            fb_q, fl_q;
	logic                   last_step;
	logic                   in_use;
	logic [63:0]            head_end;
	logic                   covers;
	logic                   dec_lower, dec_upper;
	logic [1:0]             pieces;
	logic [CW:0]            need_cnt;
	logic                   dec_full;
	logic                   retype_ok;
	logic [CW-1:0]          tail_pos, piece_pos;

	// Head of the chain is cell 0; rotation feeds head back into the tail.
	for (genvar g = 0; g < N; g++) begin : g_cell
		mrts_cell u_cell (
			.clk(clk),
			.op(cop),
			.prev(g == N-1 ? ent[0] : ent[(g+1) % N]),
			.load(load_ent),
			.load_en(g == N-1 ? tail_load : 1'b0),
			.ent(ent[g])
		);
	end

	// Head entry against the request.
	assign last_step = step_q == CW'(N - 1);
	assign in_use    = step_q < count_q;
	assign head_end  = ent[0].base + ent[0].length;
	assign covers    = (ent[0].base <= req_q.range_base) && (head_end >= end_q);

	// Pieces left by the hit entry and room for them.
	assign dec_lower = hitent_q.base < req_q.range_base;
	assign dec_upper = end_q < hend_q;
	assign pieces    = 2'd1 + 2'(dec_lower) + 2'(dec_upper);
	assign need_cnt  = {1'b0, count_q} + (CW+1)'(pieces);
	assign dec_full  = need_cnt > (CW+1)'(N + 1);
	assign retype_ok = !sealed_q && hit_q && (inram_q || req_q.range_type != soft_q) && !dec_full;

	// Tail position after the drop and the piece due at this step.
	assign tail_pos  = count_q - CW'(1);
	assign piece_pos = step_q - tail_pos;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			mrts_pkg::S_IDLE: begin
				if (start) state_d = mrts_pkg::S_SCAN;
			end
			mrts_pkg::S_SCAN: begin
				if (last_step) state_d = mrts_pkg::S_DECIDE;
			end
			mrts_pkg::S_DECIDE: begin
				if (req_q.func == mrts_pkg::FUNC_RETYPE && retype_ok) state_d = mrts_pkg::S_ROT;
				else state_d = mrts_pkg::S_DONE;
			end
			mrts_pkg::S_ROT: begin
				if (last_step) state_d = mrts_pkg::S_DONE;
			end
			mrts_pkg::S_DONE: state_d = mrts_pkg::S_IDLE;
			default: state_d = mrts_pkg::S_IDLE;
		endcase
	end

	// Chain controls: rotate in the scan and rotate states, load the tail where an entry lands.
	always_comb begin
		cop       = mrts_pkg::CELL_HOLD;
		tail_load = 1'b0;
		load_ent  = '{base: req_q.range_base, length: req_q.range_length,
			rtype: req_q.range_type};
		case (state_q)
			mrts_pkg::S_SCAN: begin
				cop = mrts_pkg::CELL_ROT;
				if (req_q.func == mrts_pkg::FUNC_ADD && !sealed_q && step_q == count_q) begin
					cop       = mrts_pkg::CELL_LOAD;
					tail_load = 1'b1;
				end
			end
			mrts_pkg::S_ROT: begin
				cop = mrts_pkg::CELL_ROT;
				if (step_q >= CW'(hitidx_q) && (step_q + CW'(1)) < count_q) begin
					// Shift the later entries down over the dropped one.
					cop       = mrts_pkg::CELL_LOAD;
					tail_load = 1'b1;
					load_ent  = ent[1];
				end else if (step_q >= tail_pos) begin
					if (lower_q && piece_pos == CW'(0)) begin
						cop       = mrts_pkg::CELL_LOAD;
						tail_load = 1'b1;
						load_ent  = '{base: hitent_q.base,
							length: req_q.range_base - hitent_q.base, rtype: hitent_q.rtype};
					end else if (piece_pos == (lower_q ? CW'(1) : CW'(0))) begin
						cop       = mrts_pkg::CELL_LOAD;
						tail_load = 1'b1;
					end else if (upper_q && piece_pos == (lower_q ? CW'(2) : CW'(1))) begin
						cop       = mrts_pkg::CELL_LOAD;
						tail_load = 1'b1;
						load_ent  = '{base: end_q, length: hend_q - end_q,
							rtype: hitent_q.rtype};
					end
				end
			end
			default: cop = mrts_pkg::CELL_HOLD;
		endcase
	end

	// Sequencer registers, configuration and result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= mrts_pkg::S_IDLE;
			req_q    <= '0;
			end_q    <= '0;
			ram_q    <= 32'd1;
			soft_q   <= 32'hEFFF_FFFF;
			count_q  <= '0;
			sealed_q <= 1'b0;
			step_q   <= '0;
			hit_q    <= 1'b0;
			inram_q  <= 1'b0;
			hitidx_q <= '0;
			hitent_q <= '0;
			hend_q   <= '0;
			lower_q  <= 1'b0;
			upper_q  <= 1'b0;
			pieces_q <= '0;
			status_q <= mrts_pkg::ST_OK;
			fb_q     <= '0;
			fl_q     <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (cfg_index == mrts_pkg::CFG_RAM) ram_q <= cfg_data;
				else soft_q <= cfg_data;
			end
			case (state_q)
				mrts_pkg::S_IDLE: begin
					if (start) begin
						req_q   <= in_item;
						end_q   <= in_item.range_base + in_item.range_length;
						step_q  <= '0;
						hit_q   <= 1'b0;
						inram_q <= 1'b0;
						fb_q    <= '0;
						fl_q    <= '0;
					end
				end
				mrts_pkg::S_SCAN: begin
					step_q <= last_step ? '0 : step_q + CW'(1);
					if (in_use) begin
						case (mrts_pkg::func_t'(req_q.func))
							mrts_pkg::FUNC_GET: begin
								if (8'(step_q) == req_q.entry_index &&
										ent[0].rtype == req_q.range_type) begin
									hit_q <= 1'b1;
									fb_q  <= ent[0].base;
									fl_q  <= ent[0].length;
								end
							end
							mrts_pkg::FUNC_RETYPE: begin
								// Keep the first covering entry; note any covering RAM entry.
								if (covers && !hit_q) begin
									hit_q    <= 1'b1;
									hitidx_q <= step_q[IW-1:0];
									hitent_q <= ent[0];
									hend_q   <= head_end;
								end
								if (covers && ent[0].rtype == ram_q) inram_q <= 1'b1;
							end
							default: ;
						endcase
					end
				end
				mrts_pkg::S_DECIDE: begin
					lower_q  <= dec_lower;
					upper_q  <= dec_upper;
					pieces_q <= pieces;
					case (mrts_pkg::func_t'(req_q.func))
						mrts_pkg::FUNC_ADD: begin
							if (sealed_q) begin
								status_q <= mrts_pkg::ST_SEALED;
							end else if (count_q >= CW'(N)) begin
								status_q <= mrts_pkg::ST_FULL;
							end else begin
								status_q <= mrts_pkg::ST_OK;
								count_q  <= count_q + CW'(1);
							end
						end
						mrts_pkg::FUNC_SEAL: begin
							sealed_q <= 1'b1;
							status_q <= mrts_pkg::ST_OK;
						end
						mrts_pkg::FUNC_GET: begin
							status_q <= hit_q ? mrts_pkg::ST_OK : mrts_pkg::ST_REJECT;
						end
						default: begin
							if (sealed_q) status_q <= mrts_pkg::ST_SEALED;
							else if (req_q.range_type == soft_q && !inram_q)
								status_q <= mrts_pkg::ST_REJECT;
							else if (!hit_q) status_q <= mrts_pkg::ST_REJECT;
							else if (dec_full) status_q <= mrts_pkg::ST_FULL;
							else status_q <= mrts_pkg::ST_OK;
						end
					endcase
				end
				mrts_pkg::S_ROT: begin
					step_q <= last_step ? '0 : step_q + CW'(1);
					if (last_step) count_q <= count_q - CW'(1) + CW'(pieces_q);
				end
				default: ;
			endcase
		end
	end

	assign busy     = state_q != mrts_pkg::S_IDLE;
	assign done     = state_q == mrts_pkg::S_DONE;
	assign out_item = '{status: status_q, found_base: fb_q, found_length: fl_q,
		entry_count: count_q};

	// Result strobe lasts one cycle and only while busy.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done);
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n) done |-> busy);
	// An accepted item raises busy.
	a_accept: assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy);
	// Count never passes capacity.
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(N));
	// The tail loads only while the chain moves.
	a_tail_load: assert property (@(posedge clk) disable iff (!arst_n)
		tail_load |-> (cop == mrts_pkg::CELL_LOAD));

endmodule

/* bench/testbench.sv */
// Testbench: drives the range table with directed and random items and checks every result.
`timescale 1ns / 100ps

module testbench;

	localparam int TableDepth = mrts_pkg::MaxEntries;

	// Track the table and compare each result with the oldest expected one.
	class range_scoreboard;
		logic [63:0] tbl_base[TableDepth];
		logic [63:0] tbl_len[TableDepth];
		logic [31:0] tbl_type[TableDepth];
		int unsigned n_entries;
		bit          is_sealed;
		logic [31:0] ram_code;
		logic [31:0] soft_code;
		mrts_pkg::out_item_t pending_q[$];
		int unsigned n_errors;

		function void clear();
			n_entries = 0;
			is_sealed = 0;
			ram_code  = 32'd1;
			soft_code = 32'hEFFF_FFFF;
			n_errors  = 0;
		endfunction

		function void set_reg(logic idx, logic [31:0] val);
			if (idx == mrts_pkg::CFG_RAM) ram_code = val;
			else soft_code = val;
		endfunction

		function bit covers(int unsigned k, logic [63:0] s, logic [63:0] e);
			logic [63:0] ke;
			ke = tbl_base[k] + tbl_len[k];
			return tbl_base[k] <= s && ke >= e;
		endfunction

		function void push_entry(logic [63:0] b, logic [63:0] l, logic [31:0] t);
			if (n_entries < TableDepth) begin
				tbl_base[n_entries] = b;
				tbl_len[n_entries]  = l;
				tbl_type[n_entries] = t;
				n_entries++;
			end
		endfunction

		function mrts_pkg::status_t retype(logic [63:0] s, logic [63:0] l, logic [31:0] t);
			logic [63:0] e, hs, he;
			logic [31:0] ht;
			int unsigned hit, pieces;
			bit in_ram, lo, hi;
			e = s + l;
			hit = n_entries;
			in_ram = 0;
			if (is_sealed) return mrts_pkg::ST_SEALED;
			if (t == soft_code) begin
				for (int unsigned i = 0; i < n_entries; i++)
					if (!in_ram && tbl_type[i] == ram_code && covers(i, s, e)) in_ram = 1;
				if (!in_ram) return mrts_pkg::ST_REJECT;
			end
			for (int unsigned i = 0; i < n_entries; i++)
				if (hit == n_entries && covers(i, s, e)) hit = i;
			if (hit >= n_entries) return mrts_pkg::ST_REJECT;
			hs = tbl_base[hit];
			he = hs + tbl_len[hit];
			ht = tbl_type[hit];
			lo = hs < s;
			hi = e < he;
			pieces = 1 + lo + hi;
			if (n_entries - 1 + pieces > TableDepth) return mrts_pkg::ST_FULL;
			for (int unsigned i = hit; i + 1 < n_entries; i++) begin
				tbl_base[i] = tbl_base[i + 1];
				tbl_len[i]  = tbl_len[i + 1];
				tbl_type[i] = tbl_type[i + 1];
			end
			n_entries--;
			if (lo) push_entry(hs, s - hs, ht);
			push_entry(s, l, t);
			if (hi) push_entry(e, he - e, ht);
			return mrts_pkg::ST_OK;
		endfunction

		// Note an accepted item and queue its expected result.
		function void note_item(mrts_pkg::in_item_t it);
			mrts_pkg::out_item_t r;
			r = '0;
			r.status = mrts_pkg::ST_OK;
			case (mrts_pkg::func_t'(it.func))
				mrts_pkg::FUNC_ADD: begin
					if (is_sealed) r.status = mrts_pkg::ST_SEALED;
					else if (n_entries >= TableDepth) r.status = mrts_pkg::ST_FULL;
					else push_entry(it.range_base, it.range_length, it.range_type);
				end
				mrts_pkg::FUNC_SEAL: is_sealed = 1;
				mrts_pkg::FUNC_GET: begin
					if (it.entry_index < n_entries &&
							tbl_type[it.entry_index] == it.range_type) begin
						r.found_base   = tbl_base[it.entry_index];
						r.found_length = tbl_len[it.entry_index];
					end else begin
						r.status = mrts_pkg::ST_REJECT;
					end
				end
				default: r.status = retype(it.range_base, it.range_length, it.range_type);
			endcase
			r.entry_count = n_entries[5:0];
			pending_q.push_back(r);
		endfunction

		function void check_result(mrts_pkg::out_item_t got);
			mrts_pkg::out_item_t w;
			if (pending_q.size() == 0) begin
				$error("result with nothing expected: %p", got);
				n_errors++;
				return;
			end
			w = pending_q.pop_front();
			if (got.status !== w.status) begin
				$error("status: expected %0d, got %0d", w.status, got.status);
				n_errors++;
			end
			if (got.found_base !== w.found_base) begin
				$error("found_base: expected %h, got %h", w.found_base, got.found_base);
				n_errors++;
			end
			if (got.found_length !== w.found_length) begin
				$error("found_length: expected %h, got %h", w.found_length, got.found_length);
				n_errors++;
			end
			if (got.entry_count !== w.entry_count) begin
				$error("entry_count: expected %0d, got %0d", w.entry_count, got.entry_count);
				n_errors++;
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                start;
	mrts_pkg::in_item_t  in_item;
	logic                busy;
	logic                done;
	mrts_pkg::out_item_t out_item;
	logic                cfg_we;
	logic                cfg_index;
	logic [31:0]         cfg_data;

	range_scoreboard table_sb;
	bit              calm;

	memory_range_table_split i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.in_item  (in_item),
		.busy     (busy),
		.done     (done),
		.out_item (out_item),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Check each strobed result at the edge that ends its cycle.
	always @(posedge clk) begin
		if (arst_n && done) table_sb.check_result(out_item);
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Present one item and hold it until the block takes it.
	task automatic send_item(mrts_pkg::func_t f, logic [63:0] b, logic [63:0] l,
			logic [31:0] t, logic [7:0] idx);
		mrts_pkg::in_item_t it;
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 8);
			repeat (gap) @(posedge clk);
		end
		it.func = f;
		it.range_base = b;
		it.range_length = l;
		it.range_type = t;
		it.entry_index = idx;
		start   <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (busy);
		table_sb.note_item(it);
		start <= 1'b0;
		// Let busy rise before the next handshake is examined.
		@(posedge clk);
	endtask

	task automatic drain();
		while (table_sb.pending_q.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		table_sb.set_reg(idx, val);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Pick a random item: mostly retypes, most of them within an existing entry.
	task automatic random_item();
		int unsigned k, n;
		logic [63:0] b, l, off, sl;
		logic [31:0] t;
		n = table_sb.n_entries;
		case ($urandom_range(0, 9))
			0, 1: send_item(mrts_pkg::FUNC_ADD, rand64(),
				$urandom_range(0, 3) ? {32'd0, $urandom} : rand64(),
				$urandom_range(0, 1) ? table_sb.ram_code : $urandom, 8'($urandom));
			2, 3: begin
				k = n ? $urandom_range(0, n - 1) : 0;
				t = (n && $urandom_range(0, 3)) ? table_sb.tbl_type[k] : $urandom;
				send_item(mrts_pkg::FUNC_GET, rand64(), rand64(), t,
					$urandom_range(0, 4) ? k[7:0] : 8'($urandom));
			end
			4: send_item(mrts_pkg::FUNC_RETYPE, rand64(), rand64(), $urandom, 8'($urandom));
			default: begin
				if (n == 0) begin
					send_item(mrts_pkg::FUNC_ADD, rand64(), rand64(), table_sb.ram_code,
						8'($urandom));
				end else begin
					k = $urandom_range(0, n - 1);
					b = table_sb.tbl_base[k];
					l = table_sb.tbl_len[k];
					off = l ? (rand64() % l) : 0;
					sl = (l - off + 1) ? (rand64() % (l - off + 1)) : rand64();
					if ($urandom_range(0, 4) == 0) begin
						off = 0;
						sl = l;
					end
					case ($urandom_range(0, 3))
						0: t = table_sb.soft_code;
						1: t = table_sb.ram_code;
						default: t = $urandom;
					endcase
					send_item(mrts_pkg::FUNC_RETYPE, b + off, sl, t, 8'($urandom));
				end
			end
		endcase
	endtask

	initial begin
		table_sb = new();
		table_sb.clear();
		calm = 0;
		arst_n = 0;
		start = 0;
		in_item = '0;
		cfg_we = 0;
		cfg_index = mrts_pkg::CFG_RAM;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, extremes, wrapping, soft-reserved cases.
		send_item(mrts_pkg::FUNC_GET, '0, '0, 32'd1, 8'd0);
		send_item(mrts_pkg::FUNC_RETYPE, 64'd10, 64'd1, 32'd5, 8'd0);
		send_item(mrts_pkg::FUNC_ADD, 64'h1000, 64'h1000, 32'd1, 8'hFF);
		send_item(mrts_pkg::FUNC_ADD, '1, '1, '1, 8'hFF);
		send_item(mrts_pkg::FUNC_ADD, 64'hFFFF_FFFF_FFFF_FF00, 64'h200, 32'd2, 8'd0);
		send_item(mrts_pkg::FUNC_GET, '1, '1, 32'd1, 8'd0);
		send_item(mrts_pkg::FUNC_GET, '0, '0, '1, 8'd1);
		send_item(mrts_pkg::FUNC_GET, '0, '0, 32'd1, 8'hFF);
		send_item(mrts_pkg::FUNC_RETYPE, 64'h2800, 64'h100, 32'hEFFF_FFFF, 8'd0);
		send_item(mrts_pkg::FUNC_RETYPE, 64'h1800, 64'h100, 32'hEFFF_FFFF, 8'd0);
		send_item(mrts_pkg::FUNC_RETYPE, 64'hFFFF_FFFF_FFFF_FF80, 64'h10, 32'd7, 8'd0);
		send_item(mrts_pkg::FUNC_RETYPE, 64'h1000, 64'h1000, 32'd9, 8'd0);
		send_item(mrts_pkg::FUNC_GET, '0, '0, 32'd9, 8'd3);
		for (int i = 0; i < 30; i++)
			send_item(mrts_pkg::FUNC_ADD, 64'(i) << 20, 64'h100, 32'd1, 8'd0);
		send_item(mrts_pkg::FUNC_RETYPE, 64'h10_0010, 64'h10, 32'd3, 8'd0);
		send_item(mrts_pkg::FUNC_SEAL, '0, '0, '0, 8'd0);
		send_item(mrts_pkg::FUNC_SEAL, '1, '1, '1, 8'hFF);
		send_item(mrts_pkg::FUNC_ADD, '0, '0, '0, 8'd0);
		send_item(mrts_pkg::FUNC_RETYPE, 64'h20_0000, 64'h10, 32'd3, 8'd0);
		send_item(mrts_pkg::FUNC_GET, '0, '0, 32'd1, 8'd31);
		drain();

		// Registers: extremes; the table stays sealed, so only get is useful.
		write_reg(mrts_pkg::CFG_RAM, '0);
		write_reg(mrts_pkg::CFG_SOFT, '1);
		send_item(mrts_pkg::FUNC_GET, '0, '0, 32'd3, 8'd31);
		drain();
		write_reg(mrts_pkg::CFG_RAM, '1);
		write_reg(mrts_pkg::CFG_SOFT, '0);
		drain();

		// Random: sealed table still answers get, seal, add and retype refusals.
		for (int i = 0; i < 750; i++) begin
			if (i == 400) begin
				drain();
				write_reg(mrts_pkg::CFG_RAM, $urandom);
				write_reg(mrts_pkg::CFG_SOFT, $urandom);
			end
			if (i > 650) calm = 1;
			if ($urandom_range(0, 9) == 0)
				send_item(mrts_pkg::FUNC_SEAL, rand64(), rand64(), $urandom, 8'($urandom));
			else random_item();
		end
		drain();
		if (table_sb.n_errors == 0 && table_sb.pending_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
